// ===== sv/tss_pkg.sv =====
// Package for the tridiagonal system solver: Q-format constants, sizes and
// saturating fixed-point helpers. No dependencies.
package tss_pkg;

	localparam int DataWidth = 32;
	localparam int DefMaxRows = 64;
	localparam int DefFracBits = 16;
	localparam int RowIdxWidth = 6;

	localparam logic signed [DataWidth-1:0] SatMax = 32'sh7fff_ffff;
	localparam logic signed [DataWidth-1:0] SatMin = 32'sh8000_0000;

	typedef logic signed [DataWidth-1:0] word_t;

	// Clamp a 66-bit signed value to 32 bits
	function automatic word_t sat_wide(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return SatMax;
		end else if (v < -66'sd2147483648) begin
			return SatMin;
		end
		return v[DataWidth-1:0];
	endfunction

	// Exact difference, saturated
	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [DataWidth:0] d;
		d = {a[DataWidth-1], a} - {b[DataWidth-1], b};
		if (d[DataWidth] != d[DataWidth-1]) begin
			return d[DataWidth] ? SatMin : SatMax;
		end
		return d[DataWidth-1:0];
	endfunction

endpackage

// ===== sv/tridiagonal_system_solver.sv =====
// Tridiagonal solver top level: sequencer, coefficient memories, multiply
// and divide units. Depends on tss_pkg, tss_mul, tss_div.
//
// Usage: each request on s_axis is one row of the system. tdata holds
// sub_diag, main_diag, super_diag, rhs (lowest bits first); tlast marks the
// final row. Rows are eliminated as they arrive and c' and d' are kept in
// two synchronous memories. Each row passes two quotients through the
// shared radix-2 divider. After the last row, back substitution emits one
// result per row from the last row down to row 0 on m_axis, each result
// taking a memory read plus a registered multiply. m_axis tdata holds
// solution, row_index; tuser holds pivot_error; tlast is set on row 0. A
// single output register holds a result until taken; a stalled receiver
// halts back substitution. No new row is taken until the run is fully
// delivered. Reset clears the row count, error flag and sequencer; the
// memories are not cleared. A run longer than MAX_ROWS ends at row
// MAX_ROWS-1 as if tlast were set.
module tridiagonal_system_solver #(
	parameter int MAX_ROWS = tss_pkg::DefMaxRows,
	parameter int FRAC_BITS = tss_pkg::DefFracBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [127:0] s_axis_tdata, // sub_diag, main_diag, super_diag, rhs
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // solution, row_index, zero fill
	output logic m_axis_tlast,
	output logic m_axis_tuser // pivot_error
);
	import tss_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = AW + 1;

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StRdPrev = 4'd1;
	localparam logic [3:0] StMulA = 4'd2;
	localparam logic [3:0] StMulB = 4'd3;
	localparam logic [3:0] StDiv1 = 4'd4;
	localparam logic [3:0] StDiv1W = 4'd5;
	localparam logic [3:0] StDiv2 = 4'd6;
	localparam logic [3:0] StDiv2W = 4'd7;
	localparam logic [3:0] StEmit = 4'd8;
	localparam logic [3:0] StBkRd = 4'd9;
	localparam logic [3:0] StBkMul = 4'd10;
	localparam logic [3:0] StBkSub = 4'd11;

	logic [3:0] state_q;
	logic [CW-1:0] row_count_q;
	logic error_seen_q;
	logic [AW-1:0] idx_q;
	logic last_q;
	word_t a_q, b_q, c_q, d_q, p_q, x_q, cp_q;

	// Coefficient memories
	word_t csup_mem [MAX_ROWS];
	word_t crhs_mem [MAX_ROWS];
	word_t csup_rd_q, crhs_rd_q;
	logic mem_we;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	word_t csup_wd, crhs_wd;
	logic rd_en;

	// Multiply and divide units
	word_t mul_a, mul_b, mul_p;
	logic div_start, div_busy, div_done;
	word_t div_num, div_den, div_quo;

	// Output register
	logic ov_q;
	word_t osol_q;
	logic [RowIdxWidth-1:0] oidx_q;
	logic olast_q, oerr_q;

	logic accept;
	logic at_cap;
	logic last_eff;
	logic emit_go;

	tss_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .a(mul_a), .b(mul_b), .prod(mul_p)
	);

	tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .done(div_done), .quo(div_quo)
	);

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == StIdle) && !ov_q;
	assign at_cap = (row_count_q >= CW'(MAX_ROWS - 1));
	assign last_eff = s_axis_tlast || at_cap;
	assign emit_go = (state_q == StEmit) && (!ov_q || m_axis_tready);

	// Memory ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			csup_mem[wr_addr] <= csup_wd;
			crhs_mem[wr_addr] <= crhs_wd;
		end
		if (rd_en) begin
			csup_rd_q <= csup_mem[rd_addr];
			crhs_rd_q <= crhs_mem[rd_addr];
		end
	end

	// Port steering
	always_comb begin
		rd_en = (state_q == StRdPrev) || (state_q == StBkRd);
		rd_addr = (state_q == StRdPrev) ? AW'(idx_q - 1'b1) : idx_q;
		mem_we = (state_q == StDiv2W) && div_done;
		wr_addr = idx_q;
		csup_wd = last_q ? '0 : cp_q;
		crhs_wd = div_quo;
		mul_a = (state_q == StBkSub || state_q == StBkMul) ? csup_rd_q : a_q;
		mul_b = (state_q == StBkSub || state_q == StBkMul) ? x_q :
		        ((state_q == StMulA) ? csup_rd_q : crhs_rd_q);
		div_start = (state_q == StDiv1) || (state_q == StDiv2);
		div_num = (state_q == StDiv1) ? c_q : d_q;
		div_den = p_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			row_count_q <= '0;
			error_seen_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			// Load or drain the output register
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						state_q <= (row_count_q == '0) ? StDiv1 : StRdPrev;
					end
				end
				StRdPrev: state_q <= StMulA;
				StMulA: state_q <= StMulB;
				StMulB: state_q <= StDiv1;
				StDiv1: begin
					if (p_q == '0) begin
						error_seen_q <= 1'b1;
					end
					state_q <= StDiv1W;
				end
				StDiv1W: if (div_done) state_q <= StDiv2;
				StDiv2: state_q <= StDiv2W;
				StDiv2W: begin
					if (div_done) begin
						if (last_q) begin
							state_q <= StEmit;
						end else begin
							row_count_q <= row_count_q + 1'b1;
							state_q <= StIdle;
						end
					end
				end
				StEmit: begin
					if (emit_go) begin
						if (idx_q == '0) begin
							row_count_q <= '0;
							error_seen_q <= 1'b0;
							state_q <= StIdle;
						end else begin
							state_q <= StBkRd;
						end
					end
				end
				StBkRd: state_q <= StBkMul;
				StBkMul: state_q <= StBkSub;
				StBkSub: state_q <= StEmit;
				default: state_q <= StIdle;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				if (accept) begin
					a_q <= s_axis_tdata[31:0];
					b_q <= s_axis_tdata[63:32];
					p_q <= s_axis_tdata[63:32];
					c_q <= s_axis_tdata[95:64];
					d_q <= s_axis_tdata[127:96];
					last_q <= last_eff;
					idx_q <= at_cap ? AW'(MAX_ROWS - 1) : row_count_q[AW-1:0];
				end
			end
			StMulB: p_q <= sat_sub(b_q, mul_p);
			StDiv1: d_q <= (idx_q == '0) ? d_q : sat_sub(d_q, mul_p);
			StDiv2: cp_q <= div_quo;
			StDiv2W: if (div_done) x_q <= div_quo;
			StEmit: begin
				if (!ov_q || m_axis_tready) begin
					osol_q <= x_q;
					oidx_q <= RowIdxWidth'(idx_q);
					olast_q <= (idx_q == '0);
					oerr_q <= error_seen_q;
					idx_q <= idx_q - 1'b1;
				end
			end
			StBkSub: x_q <= sat_sub(crhs_rd_q, mul_p);
			default: ;
		endcase
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {2'b00, oidx_q, osol_q};
	assign m_axis_tlast = olast_q;
	assign m_axis_tuser = oerr_q;

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != StIdle) |-> !s_axis_tready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("row taken while busy");

	property p_count_cap;
		@(posedge clk) disable iff (!arst_n) row_count_q < CW'(MAX_ROWS);
	endproperty
	a_count_cap: assert property (p_count_cap) else $error("row count overflow");

	property p_end_clears;
		@(posedge clk) disable iff (!arst_n)
			(m_axis_tvalid && m_axis_tlast && state_q == StIdle) |-> row_count_q == '0;
	endproperty
	a_end_clears: assert property (p_end_clears) else $error("run end left count");

	property p_div_idle;
		@(posedge clk) disable iff (!arst_n) (state_q == StIdle) |-> !div_busy;
	endproperty
	a_div_idle: assert property (p_div_idle) else $error("divider busy while idle");

endmodule

// ===== sv/tss_div.sv =====
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on tss_pkg.
module tss_div #(
	parameter int FRAC_BITS = tss_pkg::DefFracBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  tss_pkg::word_t num,
	input  tss_pkg::word_t den,
	output logic busy,
	output logic done,
	output tss_pkg::word_t quo
);
	import tss_pkg::*;

	localparam int NumW = DataWidth + FRAC_BITS;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] dvd_q;
	logic [NumW-1:0] qt_q;
	logic [DataWidth:0] rem_q;
	logic [DataWidth-1:0] dvs_q;
	logic neg_q;
	logic zero_q;
	logic numz_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DataWidth:0] rem_sh;
	logic [DataWidth:0] rem_try;
	logic [DataWidth-1:0] num_abs;
	logic [DataWidth-1:0] den_abs;
	logic signed [65:0] qs;

	assign num_abs = num[DataWidth-1] ? DataWidth'(-num) : num;
	assign den_abs = den[DataWidth-1] ? DataWidth'(-den) : den;
	assign rem_sh = {rem_q[DataWidth-1:0], dvd_q[NumW-1]};
	assign rem_try = rem_sh - {1'b0, dvs_q};

	// Shift one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_abs, {FRAC_BITS{1'b0}}};
			dvs_q <= den_abs;
			rem_q <= '0;
			qt_q <= '0;
			neg_q <= num[DataWidth-1] ^ den[DataWidth-1];
			zero_q <= (den == '0);
			numz_q <= (num == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NumW-2:0], 1'b0};
			if (!rem_try[DataWidth]) begin
				rem_q <= rem_try;
				qt_q <= {qt_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				qt_q <= {qt_q[NumW-2:0], 1'b0};
			end
		end
	end

	// Sign and saturate; a zero divisor yields all ones, which saturates by
	// the numerator sign, except zero over zero which gives zero
	assign qs = neg_q ? -$signed({{(66-NumW){1'b0}}, qt_q})
	                  : $signed({{(66-NumW){1'b0}}, qt_q});
	assign quo = (zero_q && numz_q) ? '0 : sat_wide(qs);
	assign busy = busy_q;
	assign done = done_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q;
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done while busy");

	property p_start_busy;
		@(posedge clk) disable iff (!arst_n) start |=> busy_q;
	endproperty
	a_start_busy: assert property (p_start_busy) else $error("start did not raise busy");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done_q |=> !done_q;
	endproperty
	a_done_pulse: assert property (p_done_pulse) else $error("done longer than a cycle");

endmodule

// ===== sv/tss_mul.sv =====
// Registered fixed-point multiply: floor((a*b) >> FRAC_BITS), saturated.
// Depends on tss_pkg.
module tss_mul #(
	parameter int FRAC_BITS = tss_pkg::DefFracBits
) (
	input  logic clk,
	input  tss_pkg::word_t a,
	input  tss_pkg::word_t b,
	output tss_pkg::word_t prod
);
	import tss_pkg::*;

	logic signed [2*DataWidth-1:0] prod_s1;
	logic signed [65:0] shifted;

	// Register the raw product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	assign shifted = 66'(prod_s1 >>> FRAC_BITS);
	assign prod = sat_wide(shifted);

endmodule
